// ===== hdl/dsgt_pkg.sv =====
// Shared constants, codes and types of the guide-table discrete sampler.
`default_nettype none
package dsgt_pkg;

    localparam int MAX_OUTCOMES_DEF  = 256;
    localparam int GUIDE_ENTRIES_DEF = 64;

    localparam int WEIGHT_W  = 17;
    localparam int UNIFORM_W = 16;
    localparam int SUM_W     = 25;
    localparam int TOL_W     = 8;
    localparam int OUTCOME_W = 8;
    localparam int STATUS_W  = 3;
    localparam int S_DATA_W  = 40;

    localparam logic [WEIGHT_W-1:0] ONE_Q16 = 17'h10000;

    localparam logic [STATUS_W-1:0] ST_SAMPLE_OK = 3'd0;
    localparam logic [STATUS_W-1:0] ST_WEIGHT_OK = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISMATCH  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_READY = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TOO_MANY  = 3'd4;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef enum logic [7:0] {
        S_IDLE        = 8'b0000_0001,
        S_BUILD_START = 8'b0000_0010,
        S_BUILD       = 8'b0000_0100,
        S_GUIDE       = 8'b0000_1000,
        S_FIRST       = 8'b0001_0000,
        S_UP          = 8'b0010_0000,
        S_DOWN        = 8'b0100_0000,
        S_EMIT        = 8'b1000_0000
    } dsgt_state_t;

    typedef struct packed {
        logic [SUM_W-1:0]    sum;
        logic [WEIGHT_W-1:0] cum;
        logic                in_tol;
    } dsgt_acc_t;

endpackage
`default_nettype wire

// ===== hdl/dsgt_accum.sv =====
// Saturating weight accumulation, cumulative clamp and sum tolerance check.
`default_nettype none
module dsgt_accum (
    input  wire logic [dsgt_pkg::SUM_W-1:0]    sum_in,
    input  wire logic [dsgt_pkg::WEIGHT_W-1:0] weight,
    input  wire logic [dsgt_pkg::TOL_W-1:0]    tol,
    output dsgt_pkg::dsgt_acc_t                acc
);
    import dsgt_pkg::*;

    logic [SUM_W:0]   raw_sum;
    logic [SUM_W-1:0] sat_sum;
    logic [SUM_W-1:0] one_ext;
    logic [SUM_W-1:0] diff;

    always_comb begin
        one_ext = SUM_W'(ONE_Q16);
        raw_sum = {1'b0, sum_in} + (SUM_W+1)'(weight);
        sat_sum = raw_sum[SUM_W] ? {SUM_W{1'b1}} : raw_sum[SUM_W-1:0];
        diff    = (sat_sum > one_ext) ? (sat_sum - one_ext) : (one_ext - sat_sum);
        acc.sum    = sat_sum;
        acc.cum    = (sat_sum > one_ext) ? ONE_Q16 : sat_sum[WEIGHT_W-1:0];
        acc.in_tol = (diff <= SUM_W'(tol));
    end

endmodule
`default_nettype wire

// ===== hdl/discrete_sampler_guide_table.sv =====
// Guide-table discrete sampler: weight loading, guide build and sample walk.
// Usage:
//   s_ channel takes one word per item. s_tuser is the kind: 0 loads one Q1.16
//   weight, 1 draws one sample. s_tlast marks the final weight. A load writes
//   the cumulative table; the final weight checks the sum against 1.0 within
//   cfg_wr_data (written via cfg_wr_en while idle) and if so builds the guide.
//   m_ channel returns one word per item: m_tdata outcome, m_tuser status.
// Sequencing:
//   Plain load or rejected sample: S_EMIT puts the result into the output
//   register once the output slot is free.
//   Final weight: S_BUILD_START, then S_BUILD with one cumulative table read or
//   one guide write per cycle up to the last guide entry, then S_EMIT.
//   Sample: S_GUIDE, S_FIRST, then S_UP or S_DOWN walking one cumulative table
//   read per step from the guide bucket as needed, then S_EMIT.
//   s_tready is high only while the sequencer is idle; one item at a time.
// Reset: clears counts, the ready flag and the tolerance; tables need no clear.
// Stall: a finished word waits in the output register while m_tready is low;
//   the next item is still accepted, and its result waits until the slot frees.
`default_nettype none
module discrete_sampler_guide_table #(
    parameter int MAX_OUTCOMES  = dsgt_pkg::MAX_OUTCOMES_DEF,
    parameter int GUIDE_ENTRIES = dsgt_pkg::GUIDE_ENTRIES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,   // sum_tolerance
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,       // [16:0] weight, [32:17] uniform, [39:33] zero
    input  wire logic [0:0]  s_tuser,       // [0] kind
    input  wire logic        s_tlast,       // last_weight
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,       // [7:0] outcome
    output logic [2:0]       m_tuser        // [2:0] status
);
    import dsgt_pkg::*;

    localparam int IDX_W = $clog2(MAX_OUTCOMES);
    localparam int CNT_W = $clog2(MAX_OUTCOMES + 1);
    localparam int GW    = (GUIDE_ENTRIES > 1) ? $clog2(GUIDE_ENTRIES) : 1;
    localparam int PW    = UNIFORM_W + GW;
    localparam int BW    = WEIGHT_W + GW;

    dsgt_state_t state_reg, state_next;

    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [GW-1:0]        bkt_reg, bkt_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic                 ready_reg, ready_next;
    logic                 start_new_reg, start_new_next;
    logic [TOL_W-1:0]     tol_reg;
    logic [UNIFORM_W-1:0] u_reg, u_next;
    logic [IDX_W-1:0]     res_outcome_reg, res_outcome_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic                 m_tvalid_reg;
    logic [OUTCOME_W-1:0] m_tdata_reg;
    logic [STATUS_W-1:0]  m_tuser_reg;

    logic [WEIGHT_W-1:0]  cum_mem [MAX_OUTCOMES];
    logic [IDX_W-1:0]     guide_mem [GUIDE_ENTRIES];
    logic                 cum_we;
    logic [IDX_W-1:0]     cum_waddr, cum_raddr;
    logic [WEIGHT_W-1:0]  cum_wdata, cum_rdata_reg;
    logic                 guide_we;
    logic [GW-1:0]        guide_raddr;
    logic [IDX_W-1:0]     guide_rdata_reg;

    logic [WEIGHT_W-1:0]  s_weight;
    logic [UNIFORM_W-1:0] s_uniform;
    logic [CNT_W-1:0]     eff_count;
    logic [SUM_W-1:0]     eff_sum;
    logic [PW-1:0]        bkt_prod;
    logic [BW-1:0]        cum_scaled;
    logic [BW-1:0]        bkt_start;
    logic [CNT_W-1:0]     idx_inc;
    logic                 cum_le_u;
    logic                 emit_load;
    logic [IDX_W+7:0]     outcome_ext;
    dsgt_acc_t            acc;

    dsgt_accum u_accum (
        .sum_in (eff_sum),
        .weight (s_weight),
        .tol    (tol_reg),
        .acc    (acc)
    );

    assign s_weight  = s_tdata[WEIGHT_W-1:0];
    assign s_uniform = s_tdata[WEIGHT_W +: UNIFORM_W];
    assign eff_count = start_new_reg ? '0 : count_reg;
    assign eff_sum   = start_new_reg ? '0 : sum_reg;
    assign bkt_prod  = PW'(s_uniform) * PW'(GUIDE_ENTRIES);
    assign cum_scaled = BW'(cum_rdata_reg) * BW'(GUIDE_ENTRIES);
    assign bkt_start = BW'(bkt_reg) << UNIFORM_W;
    assign idx_inc   = CNT_W'(idx_reg) + CNT_W'(1);
    assign cum_le_u  = (cum_rdata_reg <= WEIGHT_W'(u_reg));
    assign emit_load = (state_reg == S_EMIT) && (!m_tvalid_reg || m_tready);
    assign outcome_ext = (IDX_W+8)'(res_outcome_reg);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        bkt_next         = bkt_reg;
        count_next       = count_reg;
        sum_next         = sum_reg;
        ready_next       = ready_reg;
        start_new_next   = start_new_reg;
        u_next           = u_reg;
        res_outcome_next = res_outcome_reg;
        res_status_next  = res_status_reg;
        cum_we           = 1'b0;
        cum_waddr        = eff_count[IDX_W-1:0];
        cum_wdata        = acc.cum;
        cum_raddr        = idx_reg;
        guide_we         = 1'b0;
        guide_raddr      = bkt_prod[UNIFORM_W +: GW];

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    res_outcome_next = '0;
                    state_next       = S_EMIT;
                    if (s_tuser[0] == KIND_SAMPLE) begin
                        if (ready_reg && (count_reg != '0)) begin
                            u_next     = s_uniform;
                            state_next = S_GUIDE;
                        end else begin
                            res_status_next = ST_NOT_READY;
                        end
                    end else begin
                        start_new_next = 1'b0;
                        ready_next     = 1'b0;
                        count_next     = eff_count;
                        sum_next       = eff_sum;
                        if (eff_count >= CNT_W'(MAX_OUTCOMES)) begin
                            res_status_next = ST_TOO_MANY;
                            start_new_next  = 1'b1;
                        end else begin
                            sum_next        = acc.sum;
                            cum_we          = 1'b1;
                            count_next      = eff_count + CNT_W'(1);
                            res_status_next = ST_WEIGHT_OK;
                            if (s_tlast) begin
                                start_new_next = 1'b1;
                                if (!acc.in_tol) begin
                                    res_status_next = ST_MISMATCH;
                                end else begin
                                    cum_wdata  = ONE_Q16;
                                    idx_next   = '0;
                                    bkt_next   = '0;
                                    state_next = S_BUILD_START;
                                end
                            end
                        end
                    end
                end
            end
            S_BUILD_START: begin
                state_next = S_BUILD;
            end
            S_BUILD: begin
                if ((idx_inc < count_reg) && (cum_scaled <= bkt_start)) begin
                    idx_next  = idx_reg + IDX_W'(1);
                    cum_raddr = idx_reg + IDX_W'(1);
                end else begin
                    guide_we = 1'b1;
                    if (bkt_reg == GW'(GUIDE_ENTRIES - 1)) begin
                        ready_next = 1'b1;
                        state_next = S_EMIT;
                    end else begin
                        bkt_next = bkt_reg + GW'(1);
                    end
                end
            end
            S_GUIDE: begin
                idx_next   = guide_rdata_reg;
                cum_raddr  = guide_rdata_reg;
                state_next = S_FIRST;
            end
            S_FIRST: begin
                res_outcome_next = idx_reg;
                res_status_next  = ST_SAMPLE_OK;
                state_next       = S_EMIT;
                if (cum_le_u) begin
                    if (idx_inc < count_reg) begin
                        idx_next   = idx_reg + IDX_W'(1);
                        cum_raddr  = idx_reg + IDX_W'(1);
                        state_next = S_UP;
                    end
                end else if (idx_reg != '0) begin
                    cum_raddr  = idx_reg - IDX_W'(1);
                    state_next = S_DOWN;
                end
            end
            S_UP: begin
                res_outcome_next = idx_reg;
                res_status_next  = ST_SAMPLE_OK;
                state_next       = S_EMIT;
                if (cum_le_u && (idx_inc < count_reg)) begin
                    idx_next   = idx_reg + IDX_W'(1);
                    cum_raddr  = idx_reg + IDX_W'(1);
                    state_next = S_UP;
                end
            end
            S_DOWN: begin
                res_outcome_next = idx_reg;
                res_status_next  = ST_SAMPLE_OK;
                state_next       = S_EMIT;
                if (!cum_le_u) begin
                    idx_next         = idx_reg - IDX_W'(1);
                    res_outcome_next = idx_reg - IDX_W'(1);
                    if (idx_reg != IDX_W'(1)) begin
                        cum_raddr  = idx_reg - IDX_W'(2);
                        state_next = S_DOWN;
                    end
                end
            end
            S_EMIT: begin
                if (emit_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cum_we) begin
            cum_mem[cum_waddr] <= cum_wdata;
        end
        cum_rdata_reg <= cum_mem[cum_raddr];
    end

    always_ff @(posedge aclk) begin
        if (guide_we) begin
            guide_mem[bkt_reg] <= idx_reg;
        end
        guide_rdata_reg <= guide_mem[guide_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            sum_reg       <= '0;
            ready_reg     <= 1'b0;
            start_new_reg <= 1'b1;
            tol_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            ready_reg     <= ready_next;
            start_new_reg <= start_new_next;
            if (cfg_wr_en) begin
                tol_reg <= cfg_wr_data;
            end
            if (emit_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg         <= idx_next;
        bkt_reg         <= bkt_next;
        u_reg           <= u_next;
        res_outcome_reg <= res_outcome_next;
        res_status_reg  <= res_status_next;
        if (emit_load) begin
            m_tdata_reg <= outcome_ext[OUTCOME_W-1:0];
            m_tuser_reg <= res_status_reg;
        end
    end

`ifndef SYNTHESIS
    a_walk_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIRST || state_reg == S_UP || state_reg == S_DOWN)
        |-> (CNT_W'(idx_reg) < count_reg))
        else $error("walk index beyond loaded outcomes");

    a_one_item_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word accepted while busy");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser <= ST_TOO_MANY))
        else $error("undefined status code");

    a_outcome_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != ST_SAMPLE_OK)) |-> (m_tdata == '0))
        else $error("nonzero outcome on a non-sample result");

    a_ready_after_build: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_BUILD && state_next == S_EMIT) |=> ready_reg)
        else $error("guide build finished without ready");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_discrete_sampler_guide_table.sv =====
// Self-checking testbench for the guide-table discrete sampler: loads, draws and stall handling.
module tb_discrete_sampler_guide_table;
    timeunit 1ns;
    timeprecision 1ps;

    import dsgt_pkg::*;

    localparam int MAX_N        = MAX_OUTCOMES_DEF;
    localparam int GUIDE_N      = GUIDE_ENTRIES_DEF;
    localparam logic [SUM_W-1:0] SUM_SAT = '1;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int DRAIN_CYCLES = 400;
    localparam int HOLD_CYCLES  = 600;
    localparam int PHASE_ITEMS  = 50;

    typedef struct packed {
        logic [OUTCOME_W-1:0] outcome;
        logic [STATUS_W-1:0]  status;
    } result_word_t;

    class draw_scoreboard;
        bit [WEIGHT_W-1:0]  cum_table [MAX_N];
        bit [OUTCOME_W-1:0] guide_table [GUIDE_N];
        bit [8:0]           entry_count;
        bit [SUM_W-1:0]     weight_sum;
        bit                 table_ready;
        bit                 fresh_load;
        bit [TOL_W-1:0]     tolerance;
        result_word_t       expected_words [$];
        int unsigned        items_in;
        int unsigned        words_out;
        int unsigned        mismatches;
        int unsigned        status_seen [5];

        function new();
            entry_count = '0;
            weight_sum  = '0;
            table_ready = 1'b0;
            fresh_load  = 1'b1;
            tolerance   = '0;
            items_in    = 0;
            words_out   = 0;
            mismatches  = 0;
            foreach (status_seen[k]) status_seen[k] = 0;
        endfunction

        function void rebuild_guide();
            int unsigned p;
            longint unsigned start;
            p = 0;
            for (int b = 0; b < GUIDE_N; b++) begin
                start = longint'(b) * longint'(ONE_Q16);
                while (p + 1 < entry_count && longint'(cum_table[p]) * GUIDE_N <= start)
                    p++;
                guide_table[b] = p[OUTCOME_W-1:0];
            end
        endfunction

        function bit [OUTCOME_W-1:0] pick_outcome(bit [UNIFORM_W-1:0] u);
            int unsigned b;
            int unsigned i;
            b = int'((longint'(u) * GUIDE_N) >> UNIFORM_W);
            if (b >= GUIDE_N) b = GUIDE_N - 1;
            i = guide_table[b];
            if (i >= entry_count) i = entry_count - 1;
            if (cum_table[i] <= u) begin
                while (i + 1 < entry_count && cum_table[i] <= u) i++;
            end else begin
                while (i > 0 && cum_table[i-1] > u) i--;
            end
            return i[OUTCOME_W-1:0];
        endfunction

        function void note_item(bit kind, bit [WEIGHT_W-1:0] weight, bit last,
                                bit [UNIFORM_W-1:0] u);
            result_word_t w;
            bit [SUM_W:0] total;
            bit [SUM_W-1:0] gap;
            w.outcome = '0;
            w.status  = ST_SAMPLE_OK;
            if (kind == KIND_SAMPLE) begin
                if (table_ready && entry_count > 0) begin
                    w.outcome = pick_outcome(u);
                    w.status  = ST_SAMPLE_OK;
                end else begin
                    w.status = ST_NOT_READY;
                end
            end else begin
                if (fresh_load) begin
                    fresh_load  = 1'b0;
                    table_ready = 1'b0;
                    entry_count = '0;
                    weight_sum  = '0;
                end
                if (entry_count >= MAX_N) begin
                    w.status    = ST_TOO_MANY;
                    table_ready = 1'b0;
                    fresh_load  = 1'b1;
                end else begin
                    total = weight_sum + weight;
                    if (total > SUM_SAT) total = SUM_SAT;
                    weight_sum = total[SUM_W-1:0];
                    cum_table[entry_count] = (weight_sum > ONE_Q16) ? ONE_Q16
                                                                    : weight_sum[WEIGHT_W-1:0];
                    entry_count++;
                    w.status = ST_WEIGHT_OK;
                    if (last) begin
                        gap = (weight_sum > ONE_Q16) ? weight_sum - ONE_Q16
                                                     : ONE_Q16 - weight_sum;
                        fresh_load = 1'b1;
                        if (gap > tolerance) begin
                            w.status    = ST_MISMATCH;
                            table_ready = 1'b0;
                        end else begin
                            cum_table[entry_count-1] = ONE_Q16;
                            rebuild_guide();
                            table_ready = 1'b1;
                        end
                    end
                end
            end
            items_in++;
            status_seen[w.status]++;
            expected_words.push_back(w);
        endfunction

        function void check_word(logic [OUTCOME_W-1:0] outcome, logic [STATUS_W-1:0] status);
            result_word_t w;
            words_out++;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: outcome %0d status %0d", outcome, status);
                return;
            end
            w = expected_words.pop_front();
            if (w.outcome !== outcome || w.status !== status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("word %0d: outcome exp %0d got %0d, status exp %0d got %0d",
                             words_out, w.outcome, outcome, w.status, status);
            end
        endfunction

        function int unsigned pending();
            return expected_words.size();
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [TOL_W-1:0]     cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;
    logic [0:0]           s_tuser;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OUTCOME_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;

    draw_scoreboard sb = new();
    int unsigned    burst_left;

    discrete_sampler_guide_table i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d words outstanding", cycles, sb.pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_word(m_tdata, m_tuser);
    end

    initial begin
        int unsigned mode;
        int unsigned mode_left;
        int unsigned tick;
        int unsigned hold_left;
        int unsigned holds_done;
        mode       = 0;
        mode_left  = 0;
        tick       = 0;
        hold_left  = 0;
        holds_done = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            tick++;
            if (hold_left == 0 && holds_done < 2 && sb.items_in >= 300 + 500 * holds_done) begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(50, 200);
                end
                mode_left--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (tick % 3 == 0);
                endcase
            end
        end
    end

    task automatic offer_word(bit kind, bit [WEIGHT_W-1:0] weight, bit last,
                              bit [UNIFORM_W-1:0] u);
        int unsigned gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tlast  <= last;
        s_tdata  <= {{(S_DATA_W-WEIGHT_W-UNIFORM_W){1'b0}}, u, weight};
        do @(posedge aclk); while (!s_tready);
        sb.note_item(kind, weight, last, u);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 7) == 0) ? 30 : $urandom_range(0, 15);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_tolerance(bit [TOL_W-1:0] value);
        wait_drained();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.tolerance = value;
    endtask

    task automatic load_distribution(int n, bit pass);
        int unsigned cuts [$];
        int offset;
        int target;
        int unsigned prev;
        int unsigned w;
        int tol;
        tol = sb.tolerance;
        if (pass) begin
            offset = int'($urandom_range(0, 2 * tol)) - tol;
        end else begin
            offset = tol + 1 + int'($urandom_range(0, 3000));
            if ($urandom_range(0, 1)) offset = -offset;
        end
        target = 65536 + offset;
        for (int k = 0; k < n - 1; k++)
            cuts.push_back(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, target));
        cuts.sort();
        cuts.push_back(target);
        prev = 0;
        for (int k = 0; k < n; k++) begin
            w    = cuts[k] - prev;
            prev = cuts[k];
            if (w > 65536) w = 65536;
            offer_word(KIND_LOAD, w[WEIGHT_W-1:0], k == n - 1, UNIFORM_W'($urandom));
        end
    endtask

    task automatic draw_samples(int n);
        int unsigned r;
        int unsigned k;
        int cv;
        bit [UNIFORM_W-1:0] u;
        for (int j = 0; j < n; j++) begin
            r = $urandom_range(0, 9);
            if (r < 6 || sb.entry_count == 0) begin
                u = UNIFORM_W'($urandom);
            end else if (r < 9) begin
                k  = $urandom_range(0, sb.entry_count - 1);
                cv = int'(sb.cum_table[k]) - int'($urandom_range(0, 1));
                if (cv < 0) cv = 0;
                if (cv > 65535) cv = 65535;
                u = cv[UNIFORM_W-1:0];
            end else begin
                u = r[0] ? '1 : '0;
            end
            offer_word(KIND_SAMPLE, WEIGHT_W'($urandom_range(0, 65536)),
                       1'($urandom_range(0, 1)), u);
        end
    endtask

    task automatic noise_items(int n);
        for (int j = 0; j < n; j++)
            offer_word(1'($urandom_range(0, 1)), WEIGHT_W'($urandom_range(0, 65536)),
                       ($urandom_range(0, 3) == 0), UNIFORM_W'($urandom));
    endtask

    task automatic run_phase(int unsigned count);
        int unsigned first;
        int unsigned r;
        int n;
        first = sb.items_in;
        while (sb.items_in - first < count) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
                load_distribution(n, $urandom_range(0, 4) != 0);
                draw_samples($urandom_range(3, 15));
            end else if (r < 85) begin
                noise_items($urandom_range(1, 6));
            end else begin
                n = $urandom_range(1, 6);
                for (int j = 0; j < n; j++)
                    offer_word(KIND_LOAD, WEIGHT_W'($urandom_range(0, 20000)), 1'b0,
                               UNIFORM_W'($urandom));
                draw_samples(2);
            end
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = KIND_LOAD;
        s_tlast     = 1'b0;
        burst_left  = 1;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // draws before any table, then a single certain outcome
        offer_word(KIND_SAMPLE, 17'd0, 1'b0, 16'd0);
        offer_word(KIND_SAMPLE, ONE_Q16, 1'b1, 16'hFFFF);
        offer_word(KIND_LOAD, ONE_Q16, 1'b1, 16'hFFFF);
        offer_word(KIND_SAMPLE, 17'd0, 1'b0, 16'd0);
        offer_word(KIND_SAMPLE, 17'd0, 1'b0, 16'hFFFF);
        // zero weight first, ties on exact cumulative values
        offer_word(KIND_LOAD, 17'd0, 1'b0, 16'h1234);
        offer_word(KIND_LOAD, 17'd16384, 1'b0, 16'd0);
        offer_word(KIND_LOAD, 17'd32768, 1'b0, 16'hFFFF);
        offer_word(KIND_LOAD, 17'd16384, 1'b1, 16'd0);
        offer_word(KIND_SAMPLE, 17'd0, 1'b0, 16'd0);
        offer_word(KIND_SAMPLE, 17'd0, 1'b0, 16'd16383);
        offer_word(KIND_SAMPLE, 17'd0, 1'b0, 16'd16384);
        offer_word(KIND_SAMPLE, 17'd0, 1'b0, 16'd49151);
        offer_word(KIND_SAMPLE, 17'd0, 1'b0, 16'd49152);
        offer_word(KIND_SAMPLE, 17'd0, 1'b0, 16'hFFFF);
        // short sum, oversized sum, off by one
        offer_word(KIND_LOAD, 17'd30000, 1'b0, 16'd0);
        offer_word(KIND_LOAD, 17'd30000, 1'b1, 16'd0);
        offer_word(KIND_SAMPLE, 17'd0, 1'b0, 16'd100);
        offer_word(KIND_LOAD, ONE_Q16, 1'b0, 16'd0);
        offer_word(KIND_LOAD, ONE_Q16, 1'b1, 16'd0);
        offer_word(KIND_LOAD, 17'd32768, 1'b0, 16'd0);
        offer_word(KIND_LOAD, 17'd32767, 1'b1, 16'd0);
        offer_word(KIND_SAMPLE, 17'd0, 1'b0, 16'd0);

        write_tolerance(8'd255);
        run_phase(PHASE_ITEMS);
        write_tolerance(8'd0);
        run_phase(PHASE_ITEMS);
        write_tolerance(TOL_W'($urandom_range(2, 254)));
        run_phase(PHASE_ITEMS);

        // full-size table, then one weight past capacity
        write_tolerance(8'd1);
        load_distribution(MAX_N, 1'b1);
        draw_samples(20);
        for (int k = 0; k <= MAX_N; k++)
            offer_word(KIND_LOAD, WEIGHT_W'($urandom_range(0, 256)),
                       (k == MAX_N) ? bit'($urandom_range(0, 1)) : 1'b0,
                       UNIFORM_W'($urandom));
        draw_samples(3);
        run_phase(PHASE_ITEMS);

        write_tolerance(8'd128);
        run_phase(PHASE_ITEMS);
        write_tolerance(TOL_W'($urandom_range(0, 255)));
        run_phase(PHASE_ITEMS);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.pending() != 0)
            $display("%0d expected words never arrived", sb.pending());
        $display("run covered %0d items: %0d weights loaded, %0d sum mismatches, %0d overflows",
                 sb.items_in, sb.status_seen[ST_WEIGHT_OK], sb.status_seen[ST_MISMATCH],
                 sb.status_seen[ST_TOO_MANY]);
        $display("draws: %0d from a ready table, %0d refused; %0d words checked, %0d bad",
                 sb.status_seen[ST_SAMPLE_OK], sb.status_seen[ST_NOT_READY],
                 sb.words_out, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
